@@ design/bdc_pkg.sv @@
`timescale 1ns / 1ps

package bdc_pkg;

   localparam int TIME_WIDTH = 40;
   localparam int DL_WIDTH   = TIME_WIDTH + 1;
   localparam int CFG_WIDTH  = 16;
   localparam int ADDR_WIDTH = 3;
   localparam int DATA_WIDTH = 32;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_WIDTH-1:0] COOLDOWN_DEFAULT = 16'd3000;

   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_TICK   = 2'd1;
   localparam logic [1:0] FUNC_SEED   = 2'd2;

   localparam logic [1:0] ST_UNKNOWN = 2'd0;
   localparam logic [1:0] ST_IDLE    = 2'd1;
   localparam logic [1:0] ST_PRESSED = 2'd2;

   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_COOLDOWN = 1'b1;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_time;
      logic [CFG_WIDTH-1:0] cooldown_time;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            func;
      logic                  pressed;
      logic [TIME_WIDTH-1:0] now_ms;
   } item_type;

   typedef struct packed {
      logic       press_event;
      logic [1:0] stable_state;
   } result_type;

endpackage

@@ design/bdc_csr.sv @@
`timescale 1ns / 1ps

module bdc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bdc_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [bdc_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [bdc_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                             pready,
   output bdc_pkg::cfg_type                 cfg
);
   import bdc_pkg::*;

   logic [CFG_WIDTH-1:0] debounce_ff;
   logic [CFG_WIDTH-1:0] cooldown_ff;
   logic                 wr_en;
   logic                 reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         cooldown_ff <= COOLDOWN_DEFAULT;
      end else if (wr_en) begin
         case (reg_sel)
            REG_DEBOUNCE: debounce_ff <= pwdata[CFG_WIDTH-1:0];
            REG_COOLDOWN: cooldown_ff <= pwdata[CFG_WIDTH-1:0];
            default:      debounce_ff <= debounce_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEBOUNCE: prdata = {{(DATA_WIDTH-CFG_WIDTH){1'b0}}, debounce_ff};
         REG_COOLDOWN: prdata = {{(DATA_WIDTH-CFG_WIDTH){1'b0}}, cooldown_ff};
         default:      prdata = '0;
      endcase
   end

   assign cfg.debounce_time = debounce_ff;
   assign cfg.cooldown_time = cooldown_ff;

endmodule

@@ design/bdc_core.sv @@
`timescale 1ns / 1ps

module bdc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_go,
   input  bdc_pkg::item_type   item,
   input  bdc_pkg::cfg_type    cfg,
   output bdc_pkg::result_type result
);
   import bdc_pkg::*;

   logic [1:0]          stable_ff,   stable_in;
   logic                pend_v_ff,   pend_v_in;
   logic                pend_l_ff,   pend_l_in;
   logic [DL_WIDTH-1:0] db_dl_ff,    db_dl_in;
   logic                armed_ff,    armed_in;
   logic [DL_WIDTH-1:0] cd_dl_ff,    cd_dl_in;
   logic                cd_on_ff,    cd_on_in;

   logic [DL_WIDTH-1:0]  now_ext;
   logic [CFG_WIDTH-1:0] cd_time;
   logic                 skip_same;
   logic                 skip_stable;
   logic                 do_commit;
   logic                 commit_lvl;
   logic [1:0]           next_lvl;
   logic                 emit;

   assign now_ext = {1'b0, item.now_ms};
   assign cd_time = (cfg.cooldown_time == '0) ? COOLDOWN_DEFAULT : cfg.cooldown_time;
   assign skip_same   = pend_v_ff && (pend_l_ff == item.pressed);
   assign skip_stable = (stable_ff != ST_UNKNOWN) && !pend_v_ff &&
                        ((stable_ff == ST_PRESSED) == item.pressed);

   always_comb begin
      stable_in  = stable_ff;
      pend_v_in  = pend_v_ff;
      pend_l_in  = pend_l_ff;
      db_dl_in   = db_dl_ff;
      armed_in   = armed_ff;
      cd_dl_in   = cd_dl_ff;
      cd_on_in   = cd_on_ff;
      do_commit  = 1'b0;
      commit_lvl = pend_l_ff;
      emit       = 1'b0;

      case (item.func)
         FUNC_SAMPLE: begin
            if (!skip_same && !skip_stable) begin
               pend_v_in  = 1'b1;
               pend_l_in  = item.pressed;
               db_dl_in   = now_ext + {{(DL_WIDTH-CFG_WIDTH){1'b0}}, cfg.debounce_time};
               do_commit  = (cfg.debounce_time == '0);
               commit_lvl = item.pressed;
            end
         end
         FUNC_TICK: begin
            do_commit = pend_v_ff && (now_ext >= db_dl_ff);
         end
         FUNC_SEED: begin
            pend_v_in = 1'b0;
            stable_in = item.pressed ? ST_PRESSED : ST_IDLE;
            armed_in  = !item.pressed;
         end
         default: begin
         end
      endcase

      next_lvl = commit_lvl ? ST_PRESSED : ST_IDLE;
      if (do_commit) begin
         pend_v_in = 1'b0;
         if (stable_ff != next_lvl) begin
            stable_in = next_lvl;
            if (!commit_lvl) begin
               armed_in = 1'b1;
            end else if (!armed_ff || (cd_on_ff && (now_ext < cd_dl_ff))) begin
               armed_in = 1'b0;
            end else begin
               armed_in = 1'b0;
               cd_on_in = 1'b1;
               cd_dl_in = now_ext + {{(DL_WIDTH-CFG_WIDTH){1'b0}}, cd_time};
               emit     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= ST_UNKNOWN;
         pend_v_ff <= 1'b0;
         pend_l_ff <= 1'b0;
         db_dl_ff  <= '0;
         armed_ff  <= 1'b1;
         cd_dl_ff  <= '0;
         cd_on_ff  <= 1'b0;
      end else if (item_go) begin
         stable_ff <= stable_in;
         pend_v_ff <= pend_v_in;
         pend_l_ff <= pend_l_in;
         db_dl_ff  <= db_dl_in;
         armed_ff  <= armed_in;
         cd_dl_ff  <= cd_dl_in;
         cd_on_ff  <= cd_on_in;
      end
   end

   assign result.press_event  = emit;
   assign result.stable_state = stable_in;

endmodule

@@ design/button_debounce_cooldown.sv @@
`timescale 1ns / 1ps

// Button debouncer with re-arm and press cooldown.
// Input channel (req_*): one transfer per item, a raw level sample, a time
// tick or a seed of the known level, each with a millisecond timestamp.
// Result channel (rsp_*): exactly one transfer per input item, in order,
// carrying the press-event flag and the debounced state after the item.
// Configuration: APB-style port, debounce time at 0x0, cooldown time at 0x4;
// write only while no item is in flight.
// Datapath: an item is held in the input register, processed by the core
// between it and the result register, and offered on rsp_* from the latter.
// Throughput: one item per cycle while rsp_stall is low, set by the
// combinational core update (one compare and one 41-bit add per deadline).
// Stall: a valid result register holds while rsp_stall is high; one more item
// waits in the input register, after which req_stall rises.
// Reset: both registers empty, debounced state unknown, button armed,
// cooldown off, debounce 50 ms, cooldown 3000 ms.

module button_debounce_cooldown (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_func,
   input  logic                             req_pressed,
   input  logic [bdc_pkg::TIME_WIDTH-1:0]   req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_press_event,
   output logic [1:0]                       rsp_stable_state,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bdc_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [bdc_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [bdc_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                             pready
);
   import bdc_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type core_res;
   logic       advance;

   bdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.func    <= req_func;
         item_ff.pressed <= req_pressed;
         item_ff.now_ms  <= req_now_ms;
      end
   end

   bdc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item_go (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_press_event  = out_ff.press_event;
   assign rsp_stable_state = out_ff.stable_state;

   a_press_event_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_event |-> rsp_stable_state == ST_PRESSED)
      else $error("press event without pressed state");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid && rsp_stall)
      else $error("input stalled while the result side can move");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(out_ff))
      else $error("stalled result changed");

endmodule

@@ bench/button_debounce_cooldown_tb.sv @@
`timescale 1ns / 1ps

module button_debounce_cooldown_tb;
   import bdc_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_func = FUNC_TICK;
   logic                  req_pressed = 1'b0;
   logic [TIME_WIDTH-1:0] req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_press_event;
   logic [1:0]            rsp_stable_state;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr = '0;
   logic [DATA_WIDTH-1:0] pwdata = '0;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;

   button_debounce_cooldown DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_pressed      (req_pressed),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_press_event  (rsp_press_event),
      .rsp_stable_state (rsp_stable_state),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   // debouncer shadow state and its register copy
   logic [CFG_WIDTH-1:0] dbc_debounce = DEBOUNCE_RESET;
   logic [CFG_WIDTH-1:0] dbc_cooldown = COOLDOWN_DEFAULT;
   logic [1:0]           dbc_stable = ST_UNKNOWN;
   logic                 dbc_pend_valid = 1'b0;
   logic                 dbc_pend_level = 1'b0;
   logic [DL_WIDTH-1:0]  dbc_settle_at = '0;
   logic                 dbc_armed = 1'b1;
   logic [DL_WIDTH-1:0]  dbc_cool_until = '0;
   logic                 dbc_cool_on = 1'b0;

   item_type   sample_q[$];
   result_type verdict_q[$];

   int burst_left = 4;
   int gap_left = 0;
   int gap_max = 0;
   logic [15:0] stall_pattern = '0;
   logic [3:0]  stall_idx = '0;
   int quiet_cycles = 0;

   int items_sent = 0;
   int results_seen = 0;
   int presses_fired = 0;
   int mismatches = 0;

   function automatic logic commit_level(input logic lvl, input logic [DL_WIDTH-1:0] now);
      logic [1:0]          next_state;
      logic [CFG_WIDTH-1:0] cool_span;
      next_state = lvl ? ST_PRESSED : ST_IDLE;
      dbc_pend_valid = 1'b0;
      if (dbc_stable == next_state)
         return 1'b0;
      dbc_stable = next_state;
      if (!lvl) begin
         dbc_armed = 1'b1;
         return 1'b0;
      end
      if (!dbc_armed || (dbc_cool_on && now < dbc_cool_until)) begin
         dbc_armed = 1'b0;
         return 1'b0;
      end
      dbc_armed = 1'b0;
      dbc_cool_on = 1'b1;
      cool_span = (dbc_cooldown == '0) ? COOLDOWN_DEFAULT : dbc_cooldown;
      dbc_cool_until = now + DL_WIDTH'(cool_span);
      return 1'b1;
   endfunction

   function automatic logic take_sample(input logic lvl, input logic [DL_WIDTH-1:0] now);
      if (dbc_pend_valid && dbc_pend_level == lvl)
         return 1'b0;
      if (dbc_stable != ST_UNKNOWN && ((dbc_stable == ST_PRESSED) == lvl) && !dbc_pend_valid)
         return 1'b0;
      dbc_pend_valid = 1'b1;
      dbc_pend_level = lvl;
      dbc_settle_at = now + DL_WIDTH'(dbc_debounce);
      if (dbc_debounce == '0)
         return commit_level(lvl, now);
      return 1'b0;
   endfunction

   function automatic result_type debounce_predict(input item_type it);
      result_type          res;
      logic [DL_WIDTH-1:0] now;
      now = {1'b0, it.now_ms};
      res.press_event = 1'b0;
      case (it.func)
         FUNC_SAMPLE: res.press_event = take_sample(it.pressed, now);
         FUNC_TICK: begin
            if (dbc_pend_valid && now >= dbc_settle_at)
               res.press_event = commit_level(dbc_pend_level, now);
         end
         FUNC_SEED: begin
            dbc_pend_valid = 1'b0;
            dbc_stable = it.pressed ? ST_PRESSED : ST_IDLE;
            dbc_armed = !it.pressed;
         end
         default: ;
      endcase
      res.stable_state = dbc_stable;
      return res;
   endfunction

   // sender: bursts from the pending queue, random gaps between them
   always @(posedge clock) begin
      item_type nxt;
      logic     took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            nxt.func = req_func;
            nxt.pressed = req_pressed;
            nxt.now_ms = req_now_ms;
            verdict_q.push_back(debounce_predict(nxt));
            items_sent++;
         end
         if (took || !req_valid) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               nxt = sample_q.pop_front();
               req_valid <= 1'b1;
               req_func <= nxt.func;
               req_pressed <= nxt.pressed;
               req_now_ms <= nxt.now_ms;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each transfer, stall on a rotating pattern
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $error("result transfer with nothing outstanding: press_event %0d stable_state %0d",
                      rsp_press_event, rsp_stable_state);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               results_seen++;
               if (rsp_press_event !== want.press_event) begin
                  $error("press_event: expected %0d, got %0d", want.press_event,
                         rsp_press_event);
                  mismatches++;
               end
               if (rsp_stable_state !== want.stable_state) begin
                  $error("stable_state: expected %0d, got %0d", want.stable_state,
                         rsp_stable_state);
                  mismatches++;
               end
               if (want.press_event)
                  presses_fired++;
            end
         end
         stall_idx <= stall_idx + 4'd1;
         rsp_stall <= stall_pattern[stall_idx];
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (sample_q.size() == 0 && verdict_q.size() == 0 && !req_valid))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("button_debounce_cooldown_tb: done, errors");
            $finish;
         end
      end
   end

   task automatic push_item(input logic [1:0] func, input logic pressed,
                            input logic [TIME_WIDTH-1:0] now);
      item_type it;
      it.func = func;
      it.pressed = pressed;
      it.now_ms = now;
      sample_q.push_back(it);
   endtask

   task automatic csr_write(input logic idx, input logic [CFG_WIDTH-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {16'($urandom_range(0, 65535)), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_DEBOUNCE)
         dbc_debounce = value;
      else
         dbc_cooldown = value;
   endtask

   task automatic wait_drained;
      while (sample_q.size() != 0 || req_valid || verdict_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic fill_phase(input int count, input logic [TIME_WIDTH-1:0] start);
      logic [TIME_WIDTH-1:0] t;
      logic                  target;
      int                    span;
      int                    cool;
      int                    r;
      t = start;
      target = $urandom_range(0, 1);
      span = int'(dbc_debounce) + 3;
      cool = (dbc_cooldown == '0) ? int'(COOLDOWN_DEFAULT) : int'(dbc_cooldown);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 4)
            t = t - TIME_WIDTH'($urandom_range(0, span));
         else if (r < 12)
            t = t + TIME_WIDTH'($urandom_range(0, span + cool));
         else
            t = t + TIME_WIDTH'($urandom_range(0, span / 2 + 1));
         if ($urandom_range(0, 9) == 0)
            target = ~target;
         r = $urandom_range(0, 99);
         if (r < 45)
            push_item(FUNC_SAMPLE, ($urandom_range(0, 4) == 0) ? ~target : target, t);
         else if (r < 85)
            push_item(FUNC_TICK, 1'($urandom_range(0, 1)), t);
         else if (r < 91)
            push_item(FUNC_SEED, 1'($urandom_range(0, 1)), t);
         else if (r < 95)
            push_item(FUNC_UNUSED, 1'($urandom_range(0, 1)), t);
         else
            push_item(FUNC_SAMPLE, 1'($urandom_range(0, 1)), t);
      end
   endtask

   int phase_debounce[PHASES] = '{0, 65535, 1, 5, 20, -1, -1, -1, 3, 12};
   int phase_cooldown[PHASES] = '{0, 65535, 1, 40, 0, -1, -1, -1, 65535, 2999};

   initial begin
      logic [TIME_WIDTH-1:0] start;
      int                    dbt;
      int                    cdt;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: debounce 50, cooldown 3000
      push_item(FUNC_TICK, 1'b1, 0);
      push_item(FUNC_UNUSED, 1'b1, 5);
      push_item(FUNC_SAMPLE, 1'b0, 10);
      push_item(FUNC_TICK, 1'b0, 59);
      push_item(FUNC_TICK, 1'b0, 60);
      push_item(FUNC_SAMPLE, 1'b1, 100);
      push_item(FUNC_SAMPLE, 1'b0, 120);
      push_item(FUNC_TICK, 1'b1, 170);
      push_item(FUNC_SAMPLE, 1'b1, 200);
      push_item(FUNC_SAMPLE, 1'b1, 210);
      push_item(FUNC_TICK, 1'b0, 250);
      push_item(FUNC_SAMPLE, 1'b0, 300);
      push_item(FUNC_TICK, 1'b0, 350);
      push_item(FUNC_SAMPLE, 1'b1, 400);
      push_item(FUNC_TICK, 1'b0, 450);
      push_item(FUNC_SEED, 1'b0, 500);
      push_item(FUNC_SEED, 1'b1, 510);
      push_item(FUNC_SAMPLE, 1'b0, 100);
      push_item(FUNC_TICK, 1'b0, 149);
      push_item(FUNC_TICK, 1'b0, 150);
      push_item(FUNC_SEED, 1'b0, TIME_MAX - 10);
      push_item(FUNC_SAMPLE, 1'b1, TIME_MAX);
      push_item(FUNC_TICK, 1'b1, TIME_MAX);
      push_item(FUNC_UNUSED, 1'b0, TIME_MAX);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         dbt = (phase_debounce[p] < 0) ? $urandom_range(0, 30) : phase_debounce[p];
         cdt = (phase_cooldown[p] < 0) ? $urandom_range(1, 200) : phase_cooldown[p];
         csr_write(REG_DEBOUNCE, CFG_WIDTH'(dbt));
         csr_write(REG_COOLDOWN, CFG_WIDTH'(cdt));
         gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 8);
         stall_pattern = (p % 4 == 0) ? 16'h0000 : 16'($urandom_range(0, 65535)) & 16'hfffe;
         case (p % 4)
            0: start = '0;
            1: start = TIME_MAX - TIME_WIDTH'(200000);
            default: start = TIME_WIDTH'({$urandom, $urandom});
         endcase
         fill_phase(PHASE_ITEMS, start);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("Sent %0d items over %0d register settings; %0d results checked.",
               items_sent, PHASES + 1, results_seen);
      $display("Qualified presses fired: %0d; mismatches: %0d.", presses_fired, mismatches);
      if (mismatches == 0 && verdict_q.size() == 0)
         $display("button_debounce_cooldown_tb: done, clean");
      else
         $display("button_debounce_cooldown_tb: done, errors");
      $finish;
   end

endmodule
